// ===== rtl/s2d_pkg.sv =====
// Package for the signed integer to decimal ASCII converter.
// Holds the shared constants and the types passed between the front, queue,
// converter and emitter. No dependencies.
package s2d_pkg;

  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned MaxDigits     = 10;
  localparam int unsigned DigitIdxWidth = 4;

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // floor(n / 10) == (n * Recip10) >> Recip10Shift for every 32-bit unsigned n.
  localparam logic [ValueWidth-1:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned           Recip10Shift = 35;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic                  neg;
    logic [ValueWidth-1:0] mag;
  } job_t;

  // Digits are stored least significant first; ndig runs from 1 to MaxDigits.
  typedef struct packed {
    logic                     neg;
    logic [DigitIdxWidth-1:0] ndig;
    digit_t [MaxDigits-1:0]   digits;
  } digit_set_t;

endpackage

// ===== rtl/s2d_channels_if.sv =====
// Valid/ready channel interfaces for the decimal converter.
// s2d_in_if carries the signed value, s2d_out_if one character. Uses s2d_pkg.
interface s2d_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [s2d_pkg::ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface s2d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ===== rtl/signed_int_to_decimal_ascii_core.sv =====
// Signed 32-bit integer to decimal ASCII text, one character per output item.
// An accepted value passes through a two-entry queue to the converter, whose
// reciprocal multiply loop forms one digit per cycle, nd digits in all (1 to 10);
// the emitter then offers the characters. A new number can be accepted and
// converted while the emitter still sends the previous one.
// Reset clears all control state; digit buffers and the queue payload are not reset.
module signed_int_to_decimal_ascii_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  s2d_in_if.sink   in_ch,
  s2d_out_if.source out_ch
);
  import s2d_pkg::*;

  logic       push;
  job_t       push_job;
  logic       full;
  logic       q_valid;
  job_t       q_job;
  logic       pop;
  logic       hand_valid;
  logic       hand_ready;
  digit_set_t hand;

  s2d_front u_front (
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  s2d_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .valid_o    (q_valid),
    .job_o      (q_job),
    .pop_i      (pop)
  );

  s2d_conv u_conv (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .job_i        (q_job),
    .pop_o        (pop),
    .hand_valid_o (hand_valid),
    .hand_o       (hand),
    .hand_ready_i (hand_ready)
  );

  s2d_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hand_valid_i (hand_valid),
    .hand_i       (hand),
    .hand_ready_o (hand_ready),
    .out_ch       (out_ch)
  );

endmodule

// ===== rtl/s2d_front.sv =====
// Front end: accepts a value and splits it into sign and unsigned magnitude.
// Depends on s2d_pkg and s2d_in_if.
module s2d_front (
  s2d_in_if.sink          in_ch,
  input  logic            full_i,
  output logic            push_o,
  output s2d_pkg::job_t   job_o
);
  import s2d_pkg::*;

  logic [ValueWidth-1:0] raw;

  assign raw          = ValueWidth'(unsigned'(in_ch.value));
  assign in_ch.ready  = !full_i;
  assign push_o       = in_ch.valid && !full_i;
  assign job_o.neg    = raw[ValueWidth-1];
  // Unsigned negation keeps the most negative value correct.
  assign job_o.mag    = raw[ValueWidth-1] ? (ValueWidth'(0) - raw) : raw;

endmodule

// ===== rtl/s2d_fifo.sv =====
// Two-entry queue between the front end and the converter.
// Depends on s2d_pkg.
module s2d_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  s2d_pkg::job_t push_job_i,
  output logic          full_o,
  output logic          valid_o,
  output s2d_pkg::job_t job_o,
  input  logic          pop_i
);
  import s2d_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== rtl/s2d_conv.sv =====
// Converter: peels one decimal digit per cycle off the magnitude, least
// significant first, using a reciprocal multiply. Depends on s2d_pkg.
module s2d_conv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  s2d_pkg::job_t       job_i,
  output logic                pop_o,
  output logic                hand_valid_o,
  output s2d_pkg::digit_set_t hand_o,
  input  logic                hand_ready_i
);
  import s2d_pkg::*;

  typedef enum logic [2:0] {
    CvIdle = 3'b001,
    CvRun  = 3'b010,
    CvHand = 3'b100
  } conv_state_e;

  conv_state_e              state_q, state_d;
  logic [ValueWidth-1:0]    cur_q, cur_d;
  logic [ValueWidth-1:0]    prev_q, prev_d;
  logic                     have_q, have_d;
  logic [DigitIdxWidth-1:0] cnt_q, cnt_d;
  logic                     neg_q, neg_d;
  digit_t [MaxDigits-1:0]   dig_q;

  logic [2*ValueWidth-1:0]  prod;
  logic [ValueWidth-1:0]    quot;
  logic [ValueWidth-1:0]    times10;
  logic [ValueWidth-1:0]    rem;
  logic                     dig_we;

  // The quotient is registered into cur_q; the remainder of the previous
  // step is formed from prev_q and that registered quotient.
  assign prod    = (2*ValueWidth)'(cur_q) * (2*ValueWidth)'(Recip10);
  assign quot    = ValueWidth'(prod >> Recip10Shift);
  assign times10 = {cur_q[ValueWidth-4:0], 3'b000} + {cur_q[ValueWidth-2:0], 1'b0};
  assign rem     = prev_q - times10;
  assign dig_we  = (state_q == CvRun) && have_q;

  assign pop_o        = (state_q == CvIdle) && valid_i;
  assign hand_valid_o = (state_q == CvHand);
  assign hand_o.neg    = neg_q;
  assign hand_o.ndig   = cnt_q;
  assign hand_o.digits = dig_q;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    have_d  = have_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    unique case (state_q)
      CvIdle: begin
        if (valid_i) begin
          cur_d   = job_i.mag;
          neg_d   = job_i.neg;
          cnt_d   = '0;
          have_d  = 1'b0;
          state_d = CvRun;
        end
      end
      CvRun: begin
        prev_d = cur_q;
        cur_d  = quot;
        have_d = 1'b1;
        if (have_q) begin
          cnt_d = cnt_q + 1'b1;
          // A zero quotient means the digit just written was the top one.
          if (cur_q == '0) begin
            state_d = CvHand;
          end
        end
      end
      CvHand: begin
        if (hand_ready_i) begin
          state_d = CvIdle;
        end
      end
      default: begin
        state_d = CvIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CvIdle;
      have_q  <= 1'b0;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      have_q  <= have_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    if (dig_we) begin
      dig_q[cnt_q] <= rem[3:0];
    end
  end

endmodule

// ===== rtl/s2d_emit.sv =====
// Emitter: holds one finished digit set and sends the sign and the digits,
// most significant first, one character per handshake. Depends on s2d_pkg.
module s2d_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hand_valid_i,
  input  s2d_pkg::digit_set_t hand_i,
  output logic                hand_ready_o,
  s2d_out_if.source           out_ch
);
  import s2d_pkg::*;

  logic                     busy_q;
  logic                     neg_q;
  logic [DigitIdxWidth-1:0] idx_q;
  digit_t [MaxDigits-1:0]   dig_q;

  logic take;
  logic is_last;
  logic load;

  assign is_last = !neg_q && (idx_q == '0);
  assign take    = busy_q && out_ch.ready;

  // A new set may load in the cycle the final character leaves.
  assign hand_ready_o = !busy_q || (take && is_last);
  assign load         = hand_valid_i && hand_ready_o;

  assign out_ch.valid     = busy_q;
  assign out_ch.char_code = neg_q ? CharMinus : (CharZero + {4'b0000, dig_q[idx_q]});
  assign out_ch.last      = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      neg_q  <= hand_i.neg;
      idx_q  <= hand_i.ndig - 1'b1;
    end else if (take) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else if (idx_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= hand_i.digits;
    end
  end

endmodule

// ===== rtl/s2d_checker.sv =====
// Port-level checks for signed_int_to_decimal_ascii_core, attached by bind.
// Depends on s2d_pkg.
module s2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] char_code_i,
  input logic       last_i
);
  import s2d_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pending_q;
  logic [3:0] nchar_q;
  logic       digit_start_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Numbers accepted but not yet finished on the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= 3'd0;
      nchar_q       <= 4'd0;
      digit_start_q <= 1'b1;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc && last_i);
      if (out_acc) begin
        nchar_q       <= last_i ? 4'd0 : nchar_q + 4'd1;
        digit_start_q <= last_i || (char_code_i == CharMinus);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_code_i) && $stable(last_i))
    else $error("output character changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_i |-> pending_q != 3'd0)
    else $error("number finished without a matching input");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && nchar_q == 4'd10 |-> last_i)
    else $error("number longer than eleven characters");

  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && digit_start_q && char_code_i == CharZero |-> last_i)
    else $error("leading zero in a multi-digit number");

endmodule

bind signed_int_to_decimal_ascii_core s2d_checker u_s2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .char_code_i (out_ch.char_code),
  .last_i      (out_ch.last)
);
